@@ sv/adaptive_uniform_quantizer_macros.svh @@
// assertion helpers for the quantizer
`ifndef ADAPTIVE_UNIFORM_QUANTIZER_MACROS_SVH
`define ADAPTIVE_UNIFORM_QUANTIZER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define AUQ_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AUQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AUQ_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define AUQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ sv/auq_pkg.sv @@
package auq_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int NUM_W    = SAMPLE_W - 1;
    localparam int STEP_W   = 32;
    localparam int LB_W     = 5;
    localparam int IDX_W    = 31;
    localparam int AMP_W    = 64;
    localparam int M_W      = 32;
    localparam int KS_W     = 34;
    localparam int PP_W     = 48;
    localparam int HALF_W   = 16;

    localparam logic [LB_W-1:0] LEVEL_BITS_RESET = 5'd8;
    localparam logic [LB_W-1:0] LEVEL_BITS_MIN   = 5'd1;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_ZERO_STEP = 1'b1;

    // word moving through the divider
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [STEP_W-1:0] rem;
        logic [NUM_W-1:0]  quo;
        logic [STEP_W-1:0] step;
        logic              neg;
        logic              zero;
    } div_t;

    // result word
    typedef struct packed {
        logic signed [AMP_W-1:0] amp;
        logic [STEP_W-1:0]       step;
        logic [IDX_W-1:0]        idx;
        logic                    status;
    } out_t;

    // output buffer status toward the pipeline
    typedef struct packed {
        logic room;
        logic full;
    } buf_stat_t;

    // half the level count, 2^(bits-1), with bits of zero read as one
    function automatic logic [STEP_W-1:0] half_levels(input logic [LB_W-1:0] bits);
        logic [LB_W-1:0] b;
        b = (bits < LEVEL_BITS_MIN) ? LEVEL_BITS_MIN : bits;
        return STEP_W'(1) << (b - LEVEL_BITS_MIN);
    endfunction

    // top index L-1
    function automatic logic [STEP_W-1:0] max_index(input logic [LB_W-1:0] bits);
        logic [STEP_W-1:0] h;
        h = half_levels(bits);
        return (h << 1) - STEP_W'(1);
    endfunction

endpackage

@@ sv/adaptive_uniform_quantizer.sv @@
// Uniform midrise quantizer with a per-word step size. Each input word carries a signed
// sample and an unsigned step; the block returns the clamped index
// k = floor(sample/step) + L/2 in 0..L-1 with L = 2^level_bits (a level_bits of zero acts
// as one), the amplitude (2k-L+1)*step in half-LSB units, the step itself, and a status
// flag that is set when the step is zero (index and amplitude then read zero). One word is
// taken per clock while the output queue has room. A result passes the restoring divider,
// one quotient bit per stage over 31 stages, preceded by an entry stage and followed by
// four stages for the clamp and the split 32x16 multiply, then a two-word output queue
// that keeps the input open while a result waits. level_bits is written on the cfg channel;
// the user must write it only while no word is in flight, which the block does not enforce.
`include "adaptive_uniform_quantizer_macros.svh"

module adaptive_uniform_quantizer import auq_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // sample [31:0], step_size [63:32]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // amplitude_half [63:0], step_out [95:64],
                                    // level_index [126:96], zero pad [127]
    output logic         m_tuser,   // status
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [LB_W-1:0] cfg_data // level_bits
);

    logic [LB_W-1:0] level_bits_reg;
    logic            en;
    logic            div_valid;
    div_t            div_data;
    logic            rec_valid;
    out_t            rec_data;
    out_t            out_data;
    buf_stat_t       buf_stat;

    // level count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_bits_reg <= LEVEL_BITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            level_bits_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // whole pipeline advances while the output queue has room
    assign en       = buf_stat.room;
    assign s_tready = en;

    auq_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_sample (s_tdata[SAMPLE_W-1:0]),
        .in_step   (s_tdata[32 +: STEP_W]),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    auq_recon u_recon (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .level_bits (level_bits_reg),
        .in_valid   (div_valid),
        .in_data    (div_data),
        .out_valid  (rec_valid),
        .out_data   (rec_data)
    );

    auq_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_valid && en),
        .push_data (rec_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data),
        .stat      (buf_stat)
    );

    // result word packing
    assign m_tdata = {1'b0, out_data.idx, out_data.step, out_data.amp};
    assign m_tuser = out_data.status;

    // a zero step never carries a nonzero index or amplitude
    `AUQ_ASSERT_IMPLY(a_zero_step_clear, aclk, aresetn, m_tvalid && out_data.status == STATUS_ZERO_STEP, out_data.idx == '0 && out_data.amp == '0, "zero step result not cleared")

    // index never exceeds L-1
    `AUQ_ASSERT_IMPLY(a_idx_range, aclk, aresetn, m_tvalid, STEP_W'(out_data.idx) <= max_index(level_bits_reg), "level index above L-1")

    // input held off only when the output queue is full
    `AUQ_ASSERT_IMPLY(a_stall_full, aclk, aresetn, !s_tready, buf_stat.full, "input stalled with queue room")

    // a waiting result stays on the bus unchanged
    `AUQ_ASSERT_NEXT(a_hold_result, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "waiting result changed")

endmodule

@@ sv/auq_div_step.sv @@
module auq_div_step import auq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic [STEP_W:0] rem_shift;
    logic [STEP_W:0] rem_diff;
    logic            q_bit;
    div_t            step_next;
    logic            valid_reg;
    div_t            data_reg;

    // one restoring division step: bring down the next numerator bit
    always_comb begin
        rem_shift = {in_data.rem, in_data.num[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, in_data.step};
        q_bit     = (rem_shift >= {1'b0, in_data.step});
        step_next = in_data;
        step_next.rem = q_bit ? rem_diff[STEP_W-1:0] : rem_shift[STEP_W-1:0];
        step_next.num = {in_data.num[NUM_W-2:0], 1'b0};
        step_next.quo = {in_data.quo[NUM_W-2:0], q_bit};
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= step_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/auq_divider.sv @@
module auq_divider import auq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic [STEP_W-1:0]   in_step,
    output logic                out_valid,
    output div_t                out_data
);

    logic       prep_valid_reg;
    div_t       prep_reg;
    div_t       prep_next;
    logic       stage_valid [0:NUM_W];
    div_t       stage_data  [0:NUM_W];

    // floor division of a negative x equals ~((~x) / d), so divide the magnitude form
    always_comb begin
        prep_next.neg  = in_sample[SAMPLE_W-1];
        prep_next.num  = in_sample[SAMPLE_W-1] ? ~in_sample[NUM_W-1:0] : in_sample[NUM_W-1:0];
        prep_next.rem  = '0;
        prep_next.quo  = '0;
        prep_next.step = in_step;
        prep_next.zero = (in_step == '0);
    end

    // entry stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= in_valid;
        end
    end

    // entry stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign stage_valid[0] = prep_valid_reg;
    assign stage_data[0]  = prep_reg;

    // one quotient bit per stage
    for (genvar i = 0; i < NUM_W; i++) begin : g_step
        auq_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign out_valid = stage_valid[NUM_W];
    assign out_data  = stage_data[NUM_W];

endmodule

@@ sv/auq_recon.sv @@
module auq_recon import auq_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic [LB_W-1:0] level_bits,
    input  logic            in_valid,
    input  div_t            in_data,
    output logic            out_valid,
    output out_t            out_data
);

    // stage a: signed quotient plus L/2
    logic                     a_valid_reg;
    logic signed [KS_W-1:0]   a_ksum_reg;
    logic [STEP_W-1:0]        a_step_reg;
    logic                     a_zero_reg;
    logic signed [SAMPLE_W-1:0] quo_s;
    logic signed [KS_W-1:0]   ksum_next;

    // stage b: clamped index and odd multiplier 2k-L+1
    logic                     b_valid_reg;
    logic [IDX_W-1:0]         b_idx_reg;
    logic signed [M_W-1:0]    b_mul_reg;
    logic [STEP_W-1:0]        b_step_reg;
    logic                     b_zero_reg;
    logic [STEP_W-1:0]        lmax;
    logic [IDX_W-1:0]         idx_next;
    logic [M_W:0]             mul_wide;

    // stage c: partial products on step halves
    logic                     c_valid_reg;
    logic signed [PP_W-1:0]   c_plo_reg;
    logic signed [PP_W-1:0]   c_phi_reg;
    logic [IDX_W-1:0]         c_idx_reg;
    logic [STEP_W-1:0]        c_step_reg;
    logic                     c_zero_reg;

    // stage d: final sum
    logic                     d_valid_reg;
    out_t                     d_reg;
    logic signed [AMP_W-1:0]  amp_next;

    always_comb begin
        quo_s     = in_data.neg ? $signed(~{1'b0, in_data.quo}) : $signed({1'b0, in_data.quo});
        ksum_next = $signed({{(KS_W-SAMPLE_W){quo_s[SAMPLE_W-1]}}, quo_s})
                  + $signed({{(KS_W-STEP_W){1'b0}}, half_levels(level_bits)});
    end

    // clamp to 0..L-1, zero step forces index and multiplier to zero
    always_comb begin
        lmax = max_index(level_bits);
        if (a_ksum_reg[KS_W-1]) begin
            idx_next = '0;
        end else if (a_ksum_reg > $signed({{(KS_W-STEP_W){1'b0}}, lmax})) begin
            idx_next = lmax[IDX_W-1:0];
        end else begin
            idx_next = a_ksum_reg[IDX_W-1:0];
        end
        if (a_zero_reg) begin
            idx_next = '0;
        end
        mul_wide = {1'b0, idx_next, 1'b0} - {1'b0, lmax};
        if (a_zero_reg) begin
            mul_wide = '0;
        end
    end

    // recombine partial products, the upper step half weighs 2^16
    always_comb begin
        amp_next = $signed({c_phi_reg, {HALF_W{1'b0}}})
                 + $signed({{(AMP_W-PP_W){c_plo_reg[PP_W-1]}}, c_plo_reg});
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (en) begin
            a_ksum_reg  <= ksum_next;
            a_step_reg  <= in_data.step;
            a_zero_reg  <= in_data.zero;

            b_idx_reg   <= idx_next;
            b_mul_reg   <= $signed(mul_wide[M_W-1:0]);
            b_step_reg  <= a_step_reg;
            b_zero_reg  <= a_zero_reg;

            c_plo_reg   <= b_mul_reg * $signed({1'b0, b_step_reg[HALF_W-1:0]});
            c_phi_reg   <= b_mul_reg * $signed({1'b0, b_step_reg[STEP_W-1:HALF_W]});
            c_idx_reg   <= b_idx_reg;
            c_step_reg  <= b_step_reg;
            c_zero_reg  <= b_zero_reg;

            d_reg.amp    <= amp_next;
            d_reg.step   <= c_step_reg;
            d_reg.idx    <= c_idx_reg;
            d_reg.status <= c_zero_reg ? STATUS_ZERO_STEP : STATUS_OK;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data  = d_reg;

endmodule

@@ sv/auq_out_buf.sv @@
module auq_out_buf import auq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_t      push_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_t      m_data,
    output buf_stat_t stat
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    out_t       head_reg;
    out_t       tail_reg;
    logic       pop;

    assign pop = m_ready && (cnt_reg != 2'd0);

    // occupancy
    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // two-entry queue, head is the word on the bus
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else begin
                head_reg <= push_data;
            end
        end else if (push && cnt_reg == 2'd0) begin
            head_reg <= push_data;
        end
        if (push && ((cnt_reg == 2'd1 && !pop) || cnt_reg == 2'd2)) begin
            tail_reg <= push_data;
        end
    end

    assign m_valid   = (cnt_reg != 2'd0);
    assign m_data    = head_reg;
    assign stat.full = (cnt_reg == 2'd2);
    assign stat.room = (cnt_reg != 2'd2);

endmodule

@@ test/tb_adaptive_uniform_quantizer.sv @@
`timescale 1ns / 1ps

module tb_adaptive_uniform_quantizer;
    import auq_pkg::*;

    localparam int NDIR     = 25;
    localparam int NPHASE   = 8;
    localparam int PHASE_N  = 107;
    localparam int HOLD_LEN = 300;

    // one directed stimulus row; res is used only when typed is set
    typedef struct {
        logic [LB_W-1:0] bits;
        logic [31:0]     smp;
        logic [31:0]     stp;
        bit              typed;
        out_t            res;
    } dir_row_t;

    localparam out_t NO_RES   = '0;
    localparam out_t ZERO_RES = '{64'sd0, 32'd0, 31'd0, STATUS_ZERO_STEP};

    logic            aclk;
    logic            aresetn   = 1'b0;
    logic            s_tvalid  = 1'b0;
    logic            s_tready;
    logic [63:0]     s_tdata   = '0;
    logic            m_tvalid;
    logic            m_tready  = 1'b0;
    logic [127:0]    m_tdata;
    logic            m_tuser;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [LB_W-1:0] cfg_data  = '0;

    // predictor copy of the register
    logic [LB_W-1:0] level_bits_cfg = LEVEL_BITS_RESET;

    out_t due_words [$];
    out_t want;
    int   mismatches = 0;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    // receiver hold-off requests, counted out in the receiver process
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    dir_row_t dir_tab [NDIR] = '{
        // reset setting: 8 bits, 256 levels
        '{5'd8,  32'h0000_0000, 32'h0000_0001, 1'b1, '{64'sd1, 32'd1, 31'd128, STATUS_OK}},
        '{5'd8,  32'hffff_ffff, 32'h0000_0001, 1'b1, '{-64'sd1, 32'd1, 31'd127, STATUS_OK}},
        '{5'd8,  32'h7fff_ffff, 32'h0000_0001, 1'b1, '{64'sd255, 32'd1, 31'd255, STATUS_OK}},
        '{5'd8,  32'h8000_0000, 32'h0000_0001, 1'b1, '{-64'sd255, 32'd1, 31'd0, STATUS_OK}},
        '{5'd8,  32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_RES},
        '{5'd8,  32'h1234_5678, 32'h0000_0000, 1'b1, ZERO_RES},
        '{5'd8,  32'h7fff_ffff, 32'hffff_ffff, 1'b1,
            '{64'sd4294967295, 32'hffff_ffff, 31'd128, STATUS_OK}},
        '{5'd8,  32'h8000_0000, 32'hffff_ffff, 1'b1,
            '{-64'sd4294967295, 32'hffff_ffff, 31'd127, STATUS_OK}},
        // floor division, negative samples exact and inexact, and a positive inexact one
        '{5'd8,  32'hffff_fff9, 32'd2, 1'b0, NO_RES},
        '{5'd8,  32'hffff_fff8, 32'd2, 1'b0, NO_RES},
        '{5'd8,  32'd100,       32'd3, 1'b0, NO_RES},
        // top and bottom index edges, just inside and just past
        '{5'd8,  32'd639,       32'd5, 1'b0, NO_RES},
        '{5'd8,  32'd640,       32'd5, 1'b0, NO_RES},
        '{5'd8,  32'hffff_fd80, 32'd5, 1'b0, NO_RES},
        '{5'd8,  32'hffff_fd7f, 32'd5, 1'b0, NO_RES},
        '{5'd8,  32'h5555_aaaa, 32'haaaa_5555, 1'b0, NO_RES},
        // zero level bits acts as one bit
        '{5'd0,  32'h0000_0000, 32'd1, 1'b0, NO_RES},
        '{5'd0,  32'hffff_ffff, 32'd1, 1'b0, NO_RES},
        '{5'd0,  32'h7fff_ffff, 32'd3, 1'b0, NO_RES},
        // widest quantizer
        '{5'd31, 32'h7fff_ffff, 32'd1, 1'b0, NO_RES},
        '{5'd31, 32'h8000_0000, 32'd1, 1'b0, NO_RES},
        '{5'd31, 32'h8000_0000, 32'hffff_ffff, 1'b0, NO_RES},
        '{5'd31, 32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_RES},
        // narrowest quantizer
        '{5'd1,  32'd5,         32'd7, 1'b0, NO_RES},
        '{5'd1,  32'hffff_fffb, 32'd7, 1'b0, NO_RES}
    };

    adaptive_uniform_quantizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // sample [31:0], step_size [63:32]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // amplitude_half [63:0], step_out [95:64],
                                 // level_index [126:96], zero pad [127]
        .m_tuser   (m_tuser),    // status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    // midrise quantizer: floor(x/step) + L/2 clamped to 0..L-1
    function automatic out_t quantize_word(input logic [31:0] smp, input logic [31:0] stp,
                                           input logic [LB_W-1:0] bits);
        out_t   r;
        longint x;
        longint s;
        longint lv;
        longint q;
        longint k;
        x  = longint'($signed(smp));
        s  = longint'(stp);
        lv = longint'(1) << ((bits == 0) ? 1 : bits);
        if (s == 0) begin
            r = ZERO_RES;
        end else begin
            q = x / s;
            if ((x % s) != 0 && x < 0)
                q = q - 1;
            k = q + lv / 2;
            if (k < 0)
                k = 0;
            if (k > lv - 1)
                k = lv - 1;
            r.amp    = (2 * k - lv + 1) * s;
            r.step   = stp;
            r.idx    = k[IDX_W-1:0];
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch on %s: got %h, want %h", field, got, exp_val);
        mismatches++;
    endtask

    // offer one word with a random lead-in gap and log its result on acceptance
    task automatic send_word(input logic [31:0] smp, input logic [31:0] stp,
                             input bit typed, input out_t given);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stp, smp};
        do @(posedge aclk); while (!s_tready);
        due_words.push_back(typed ? given : quantize_word(smp, stp, level_bits_cfg));
    endtask

    // stop offering and wait until every logged result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_level_bits(input logic [LB_W-1:0] bits);
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        level_bits_cfg = bits;
    endtask

    // random word, mostly aimed at index edges of the current setting
    task automatic pick_word(output logic [31:0] smp, output logic [31:0] stp);
        longint lv;
        longint s;
        longint j;
        longint x;
        int     r;
        lv = longint'(1) << ((level_bits_cfg == 0) ? 1 : level_bits_cfg);
        r  = $urandom_range(99);
        if (r < 4)
            stp = 32'd0;
        else if (r < 35)
            stp = $urandom_range(16, 1);
        else if (r < 55)
            stp = 32'd1 << $urandom_range(31, 0);
        else if (r < 75)
            stp = $urandom;
        else
            stp = $urandom_range(65535, 1);
        s = longint'(stp);
        r = $urandom_range(99);
        if (r < 35 || s == 0) begin
            smp = $urandom;
        end else if (r < 85) begin
            case ($urandom_range(5))
                0: j = -1;
                1: j = 0;
                2: j = 1;
                3: j = lv - 1;
                4: j = lv;
                default: j = longint'($urandom) % lv;
            endcase
            x = (j - lv / 2) * s;
            case ($urandom_range(2))
                0: ;
                1: x = x - 1;
                default: x = x + longint'($urandom) % s;
            endcase
            smp = x[31:0];
        end else begin
            case ($urandom_range(3))
                0: smp = 32'h8000_0000;
                1: smp = 32'h7fff_ffff;
                2: smp = 32'h0000_0000;
                default: smp = 32'hffff_ffff;
            endcase
        end
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result check against the oldest logged word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
            end else begin
                want = due_words.pop_front();
                if (m_tdata[63:0] !== want.amp)
                    report_mismatch("amplitude_half", m_tdata[63:0], want.amp);
                if (m_tdata[95:64] !== want.step)
                    report_mismatch("step_out", 64'(m_tdata[95:64]), 64'(want.step));
                if (m_tdata[126:96] !== want.idx)
                    report_mismatch("level_index", 64'(m_tdata[126:96]), 64'(want.idx));
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
            end
        end
    end

    // stimulus
    initial begin
        logic [31:0]     smp;
        logic [31:0]     stp;
        logic [LB_W-1:0] phase_bits [NPHASE];

        phase_bits[0] = 5'd31;
        phase_bits[1] = 5'd1;
        phase_bits[2] = 5'd0;
        phase_bits[3] = 5'd16;
        phase_bits[4] = LB_W'($urandom_range(30, 2));
        phase_bits[5] = 5'd2;
        phase_bits[6] = 5'd30;
        phase_bits[7] = LB_W'($urandom_range(31, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < NDIR; i++) begin
            if (dir_tab[i].bits != level_bits_cfg) begin
                wait_idle();
                write_level_bits(dir_tab[i].bits);
            end
            send_word(dir_tab[i].smp, dir_tab[i].stp, dir_tab[i].typed, dir_tab[i].res);
        end

        // random phases, cycling through the idling modes
        for (int p = 0; p < NPHASE; p++) begin
            wait_idle();
            write_level_bits(phase_bits[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin src_idle_pct = 30; sink_stall_pct = 30; end
            endcase
            for (int i = 0; i < PHASE_N; i++) begin
                // fill the pipeline against a held-off receiver
                if (p == 4 && i == 10)
                    hold_reqs <= hold_reqs + 1;
                pick_word(smp, stp);
                send_word(smp, stp, 1'b0, NO_RES);
            end
        end

        wait_idle();
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
